// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: sv/hmap_pkg.sv
`timescale 1ns / 1ps

package hmap_pkg;

    // Field and register widths.
    localparam int SIZE_W    = 11;
    localparam int MULT_W    = 10;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 31;
    localparam int OUT_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CIDX_W    = 2;
    localparam int DIV_STEPS = 64;

    // Defaults for the top-level parameters.
    localparam int DEF_BUCKETS = 1024;
    localparam int DEF_WAYS    = 4;

    // Register reset values.
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(1021);
    localparam logic [MULT_W-1:0] HASH_MULT_RST  = MULT_W'(1020);

    typedef enum logic [CIDX_W-1:0] {
        REG_TABLE_SIZE = 2'd0,
        REG_HASH_MULT  = 2'd1
    } reg_idx_t;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_SET    = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT    = 2'd0,
        ST_INSERT = 2'd1,
        ST_MISS   = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Status of the serial remainder unit.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: sv/two_word_key_hash_map_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        sink       in_valid / in_stall  operation, key_low, key_high, new_value
// out       source     out_valid/out_stall  value_out, status
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request passes from its input transfer through three reductions by the serial
// remainder unit (64 steps each), the way scan, the decision and the result transfer.
// After reset a clearing pass zeroes the valid rows; no request is taken meanwhile,
// configuration writes are.
// One request is in flight at a time; the result waits while out_stall is high.
module two_word_key_hash_map_core #(
    parameter int BUCKETS = hmap_pkg::DEF_BUCKETS,
    parameter int WAYS    = hmap_pkg::DEF_WAYS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        operation,
    input  logic [hmap_pkg::KEY_W-1:0]  key_low,
    input  logic [hmap_pkg::KEY_W-1:0]  key_high,
    input  logic [hmap_pkg::VAL_W-1:0]  new_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [hmap_pkg::OUT_W-1:0] value_out,
    output logic [hmap_pkg::STAT_W-1:0] status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hmap_pkg::CIDX_W-1:0] cfg_index,
    input  logic [hmap_pkg::SIZE_W-1:0] cfg_data
);
    import hmap_pkg::*;

    `include "assert_macros.svh"

    localparam int BW     = $clog2(BUCKETS);
    localparam int EW     = $clog2(BUCKETS * WAYS);
    localparam int WAYW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int PROD_W = SIZE_W + MULT_W + 1;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_MODLO  = 9'b000000100,
        S_MODHI  = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_MODK   = 9'b000100000,
        S_SCAN   = 9'b001000000,
        S_DECIDE = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration and request registers.
    logic [SIZE_W-1:0] ts_reg;
    logic [MULT_W-1:0] hm_reg;
    logic              op_reg;
    logic [KEY_W-1:0]  klo_reg;
    logic [KEY_W-1:0]  khi_reg;
    logic [VAL_W-1:0]  nv_reg;
    logic [SIZE_W-1:0] a_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [BW-1:0]     bucket_reg;
    logic [BW-1:0]     clr_reg;
    logic [WAYW-1:0]   way_reg;
    logic              match_reg;
    logic [WAYW-1:0]   match_way_reg;
    logic              free_reg;
    logic [WAYW-1:0]   free_way_reg;
    logic [VAL_W-1:0]  hit_val_reg;
    logic [OUT_W-1:0]  vout_reg;
    logic [STAT_W-1:0] stat_reg;

    // Memories and their registered read data.
    logic [WAYS-1:0]   vmem [BUCKETS];
    logic [KEY_W-1:0]  klo_mem [BUCKETS * WAYS];
    logic [KEY_W-1:0]  khi_mem [BUCKETS * WAYS];
    logic [VAL_W-1:0]  val_mem [BUCKETS * WAYS];
    logic [WAYS-1:0]   vrow_rd_reg;
    logic [KEY_W-1:0]  klo_rd_reg;
    logic [KEY_W-1:0]  khi_rd_reg;
    logic [VAL_W-1:0]  val_rd_reg;

    // Divider hookup.
    logic              div_start;
    logic [KEY_W-1:0]  div_dividend;
    div_stat_t         div_stat;
    logic [SIZE_W-1:0] div_rem;
    logic [SIZE_W-1:0] n_eff;

    // Comb controls.
    logic              in_fire;
    logic [BW-1:0]     rem_bucket;
    logic [SIZE_W+BW-1:0] rem_ext;
    logic              rd_en;
    logic [EW-1:0]     rd_addr;
    logic              vrd_en;
    logic [BW-1:0]     vrd_addr;
    logic              hit_now;
    logic              is_last;
    logic              row_we;
    logic [BW-1:0]     row_addr;
    logic [WAYS-1:0]   row_data;
    logic              key_we;
    logic              val_we;
    logic [EW-1:0]     wr_addr;
    logic [PROD_W-1:0] prod_next;
    logic [OUT_W-1:0]  vout_next;
    logic [STAT_W-1:0] stat_next;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign value_out = vout_reg;
    assign status    = stat_reg;
    assign cfg_ready = 1'b1;

    // Effective table size: zero acts as one, large values saturate.
    always_comb
    begin
        if (ts_reg == '0)
        begin
            n_eff = SIZE_W'(1);
        end
        else if (32'(ts_reg) > BUCKETS)
        begin
            n_eff = SIZE_W'(BUCKETS);
        end
        else
        begin
            n_eff = ts_reg;
        end
    end

    hmap_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n_eff),
        .stat     (div_stat),
        .rem      (div_rem)
    );

    assign rem_ext    = {{BW{1'b0}}, div_rem};
    assign rem_bucket = rem_ext[BW-1:0];
    assign prod_next  = PROD_W'(a_reg) * PROD_W'(hm_reg) + PROD_W'(div_rem);
    assign is_last    = (32'(way_reg) == WAYS - 1);
    assign hit_now    = vrow_rd_reg[way_reg] && (klo_rd_reg == klo_reg)
                        && (khi_rd_reg == khi_reg);

    // Divider start and dividend selection.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = key_low;
        if (state_reg == S_IDLE)
        begin
            div_start = in_fire;
        end
        else if (state_reg == S_MODLO)
        begin
            div_start    = div_stat.done;
            div_dividend = khi_reg;
        end
        else if (state_reg == S_MUL)
        begin
            div_start    = 1'b1;
            div_dividend = KEY_W'(prod_reg);
        end
    end

    // Read port addressing: way 0 when the bucket is known, then one way a cycle.
    always_comb
    begin
        vrd_en   = 1'b0;
        vrd_addr = rem_bucket;
        rd_en    = 1'b0;
        rd_addr  = EW'(int'(rem_bucket) * WAYS);
        if (state_reg == S_MODK && div_stat.done)
        begin
            vrd_en = 1'b1;
            rd_en  = 1'b1;
        end
        else if (state_reg == S_SCAN && !is_last)
        begin
            rd_en   = 1'b1;
            rd_addr = EW'(int'(bucket_reg) * WAYS + int'(way_reg) + 1);
        end
    end

    // Decision and write port controls.
    always_comb
    begin
        row_we    = 1'b0;
        row_addr  = clr_reg;
        row_data  = '0;
        key_we    = 1'b0;
        val_we    = 1'b0;
        wr_addr   = EW'(int'(bucket_reg) * WAYS + int'(match_way_reg));
        vout_next = '1;
        stat_next = ST_MISS;
        if (state_reg == S_CLEAR)
        begin
            row_we = 1'b1;
        end
        else if (state_reg == S_DECIDE)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                if (match_reg)
                begin
                    vout_next = {1'b0, hit_val_reg};
                    stat_next = ST_HIT;
                end
            end
            else if (match_reg)
            begin
                val_we    = 1'b1;
                stat_next = ST_HIT;
            end
            else if (free_reg)
            begin
                row_we    = 1'b1;
                row_addr  = bucket_reg;
                row_data  = vrow_rd_reg | (WAYS'(1) << free_way_reg);
                key_we    = 1'b1;
                val_we    = 1'b1;
                wr_addr   = EW'(int'(bucket_reg) * WAYS + int'(free_way_reg));
                stat_next = ST_INSERT;
            end
            else
            begin
                stat_next = ST_FULL;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_reg) == BUCKETS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_MODLO;
                end
            end
            S_MODLO:
            begin
                if (div_stat.done)
                begin
                    state_next = S_MODHI;
                end
            end
            S_MODHI:
            begin
                if (div_stat.done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:    state_next = S_MODK;
            S_MODK:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (is_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: state_next = S_OUT;
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ts_reg    <= TABLE_SIZE_RST;
            hm_reg    <= HASH_MULT_RST;
            way_reg   <= '0;
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TABLE_SIZE: ts_reg <= cfg_data;
                    REG_HASH_MULT:  hm_reg <= cfg_data[MULT_W-1:0];
                    default:        ;
                endcase
            end
            if (state_reg == S_MODK && div_stat.done)
            begin
                way_reg   <= '0;
                match_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                way_reg <= way_reg + 1'b1;
                if (hit_now && !match_reg)
                begin
                    match_reg <= 1'b1;
                end
                if (!vrow_rd_reg[way_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    // Request payload and scan results.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= operation;
            klo_reg <= key_low;
            khi_reg <= key_high;
            nv_reg  <= new_value;
        end
        if (state_reg == S_MODLO && div_stat.done)
        begin
            a_reg <= div_rem;
        end
        if (state_reg == S_MODHI && div_stat.done)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == S_MODK && div_stat.done)
        begin
            bucket_reg <= rem_bucket;
        end
        if (state_reg == S_SCAN)
        begin
            if (hit_now && !match_reg)
            begin
                match_way_reg <= way_reg;
                hit_val_reg   <= val_rd_reg;
            end
            if (!vrow_rd_reg[way_reg] && !free_reg)
            begin
                free_way_reg <= way_reg;
            end
        end
        if (state_reg == S_DECIDE)
        begin
            vout_reg <= vout_next;
            stat_reg <= stat_next;
        end
    end

    // Valid-row memory.
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            vmem[row_addr] <= row_data;
        end
        if (vrd_en)
        begin
            vrow_rd_reg <= vmem[vrd_addr];
        end
    end

    // Entry memories.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            klo_mem[wr_addr] <= klo_reg;
            khi_mem[wr_addr] <= khi_reg;
        end
        if (val_we)
        begin
            val_mem[wr_addr] <= nv_reg;
        end
        if (rd_en)
        begin
            klo_rd_reg <= klo_mem[rd_addr];
            khi_rd_reg <= khi_mem[rd_addr];
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    // A value other than all ones only comes with a lookup hit.
    `ASSERT_IMPLY(a_value_hit, clk, rst_n, out_valid && (value_out != -1), status == ST_HIT)
    // Inserts, misses and drops always report all ones.
    `ASSERT_IMPLY(a_miss_ones, clk, rst_n, out_valid && (status != ST_HIT), value_out == -1)
    // A transfer in starts the divider and blocks further requests.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, div_stat.busy && in_stall)
    // The divider finishes only while a reduction is pending.
    `ASSERT_IMPLY(a_div_done, clk, rst_n, div_stat.done,
                  state_reg == S_MODLO || state_reg == S_MODHI || state_reg == S_MODK)

endmodule

// File: sv/hmap_div.sv
`timescale 1ns / 1ps

// Serial remainder unit: one dividend bit per cycle, restoring form.
module hmap_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [hmap_pkg::KEY_W-1:0]  dividend,
    input  logic [hmap_pkg::SIZE_W-1:0] divisor,
    output hmap_pkg::div_stat_t         stat,
    output logic [hmap_pkg::SIZE_W-1:0] rem
);
    import hmap_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [KEY_W-1:0]  dvd_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic [SIZE_W-1:0] rem_next;

    // One shift and conditional subtract.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[KEY_W-1]};
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            rem_next = diff[SIZE_W-1:0];
        end
        else
        begin
            rem_next = trial[SIZE_W-1:0];
        end
    end

    // Control: step counter, busy and done flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: dividend shifter and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[KEY_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule
